### rtl/lsps_pkg.sv
// Shared types, widths, codes and helper functions of the line-sensor PID steering unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package lsps_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int INTEGRAL_BITS  = 13;
  localparam int THRESHOLD_BITS = 10;
  localparam int GAIN_BITS      = 16;
  localparam int SPEED_BITS     = 10;
  localparam int ERR_BITS       = 4;
  localparam int DERIV_BITS     = ERR_BITS + 1;
  localparam int MODE_BITS      = 2;
  localparam int OUT_BITS       = 16;
  localparam int FRAC_BITS      = 8;
  localparam int NUM_SENSORS    = 5;

  localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

  localparam int PROD_P_BITS = GAIN_BITS + 1 + ERR_BITS;
  localparam int PROD_D_BITS = GAIN_BITS + 1 + DERIV_BITS;
  localparam int PROD_I_BITS = GAIN_BITS + 1 + INTEGRAL_BITS;
  localparam int SUM_BITS    = ((PROD_I_BITS > PROD_D_BITS) ? PROD_I_BITS : PROD_D_BITS) + 2;
  localparam int QUOT_BITS   = SUM_BITS - FRAC_BITS;
  localparam int SPD_SUM_BITS = OUT_BITS + 2;

  localparam int OUT_MAX = (1 << (OUT_BITS - 1)) - 1;
  localparam int OUT_MIN = -OUT_MAX - 1;
  localparam int INT_MAX = (1 << (INTEGRAL_BITS - 1)) - 1;
  localparam int INT_MIN = -INT_MAX - 1;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_IS_DARK  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOMINAL_SPEED = 3'd5;

  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = THRESHOLD_BITS'(512);
  localparam logic [GAIN_BITS-1:0]      GAIN_P_RESET    = GAIN_BITS'(256);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_STOPPED = 2'd0,
    MODE_FOLLOW  = 2'd1,
    MODE_NOLINE  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [THRESHOLD_BITS-1:0] threshold;
    logic                      line_is_dark;
    logic [GAIN_BITS-1:0]      gain_p;
    logic [GAIN_BITS-1:0]      gain_i;
    logic [GAIN_BITS-1:0]      gain_d;
    logic [SPEED_BITS-1:0]     nominal_speed;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] far_left;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0] far_right;
  } samples_t;

  typedef struct packed {
    logic                             hit;
    logic signed [ERR_BITS-1:0]       err;
    mode_t                            mode;
  } decode_t;

  typedef struct packed {
    logic signed [ERR_BITS-1:0]       err;
    mode_t                            mode;
    logic signed [INTEGRAL_BITS-1:0]  integ;
    logic signed [DERIV_BITS-1:0]     deriv;
  } track_t;

  typedef struct packed {
    logic signed [ERR_BITS-1:0]       err;
    mode_t                            mode;
    logic signed [OUT_BITS-1:0]       pid;
  } pid_res_t;

  // Pattern bits run from far left (MSB) to far right (LSB).
  function automatic decode_t decode_pattern(input logic [NUM_SENSORS-1:0] bits);
    decode_t d;
    d.hit  = 1'b1;
    d.err  = '0;
    d.mode = MODE_FOLLOW;
    case (bits)
      5'b00001: d.err = 4'sd4;
      5'b00011: d.err = 4'sd3;
      5'b00010: d.err = 4'sd2;
      5'b00110: d.err = 4'sd1;
      5'b00100: d.err = 4'sd0;
      5'b01100: d.err = -4'sd1;
      5'b01000: d.err = -4'sd2;
      5'b11000: d.err = -4'sd3;
      5'b10000: d.err = -4'sd4;
      5'b11111: d.mode = MODE_STOPPED;
      5'b00000: d.mode = MODE_NOLINE;
      default:  d.hit = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_out(
    input logic signed [SPD_SUM_BITS-1:0] v
  );
    logic signed [OUT_BITS-1:0] r;
    if (v > SPD_SUM_BITS'(OUT_MAX)) begin
      r = OUT_BITS'(OUT_MAX);
    end else if (v < SPD_SUM_BITS'(OUT_MIN)) begin
      r = OUT_BITS'(OUT_MIN);
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lsps_sample_if.sv
// Input channel carrying the five line-sensor samples of one control tick.
// Depends on lsps_pkg for the sample width.
`default_nettype none

interface lsps_sample_if;
  logic                             valid;
  logic                             ready;
  logic [lsps_pkg::SAMPLE_BITS-1:0] sample_far_left;
  logic [lsps_pkg::SAMPLE_BITS-1:0] sample_left;
  logic [lsps_pkg::SAMPLE_BITS-1:0] sample_center;
  logic [lsps_pkg::SAMPLE_BITS-1:0] sample_right;
  logic [lsps_pkg::SAMPLE_BITS-1:0] sample_far_right;

  modport source (
    output valid, sample_far_left, sample_left, sample_center, sample_right,
           sample_far_right,
    input  ready
  );
  modport sink (
    input  valid, sample_far_left, sample_left, sample_center, sample_right,
           sample_far_right,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lsps_result_if.sv
// Output channel carrying one steering result per control tick.
// Depends on lsps_pkg for the field widths.
`default_nettype none

interface lsps_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lsps_pkg::ERR_BITS-1:0]  position_error;
  logic [lsps_pkg::MODE_BITS-1:0]        run_mode;
  logic signed [lsps_pkg::OUT_BITS-1:0]  pid_value;
  logic signed [lsps_pkg::OUT_BITS-1:0]  speed_a;
  logic signed [lsps_pkg::OUT_BITS-1:0]  speed_b;

  modport source (
    output valid, position_error, run_mode, pid_value, speed_a, speed_b,
    input  ready
  );
  modport sink (
    input  valid, position_error, run_mode, pid_value, speed_a, speed_b,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lsps_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on lsps_pkg for the index and data widths.
`default_nettype none

interface lsps_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lsps_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lsps_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/lsps_cfg.sv
// Configuration register file of the steering unit, written through the config channel.
// Depends on lsps_pkg and lsps_cfg_if.
`default_nettype none

module lsps_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  lsps_cfg_if.sink      cfg,
  output lsps_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold     <= lsps_pkg::THRESHOLD_RESET;
      regs.line_is_dark  <= 1'b1;
      regs.gain_p        <= lsps_pkg::GAIN_P_RESET;
      regs.gain_i        <= '0;
      regs.gain_d        <= '0;
      regs.nominal_speed <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lsps_pkg::REG_THRESHOLD: begin
          regs.threshold <= cfg.data[lsps_pkg::THRESHOLD_BITS-1:0];
        end
        lsps_pkg::REG_LINE_IS_DARK: begin
          regs.line_is_dark <= cfg.data[0];
        end
        lsps_pkg::REG_GAIN_P: begin
          regs.gain_p <= cfg.data[lsps_pkg::GAIN_BITS-1:0];
        end
        lsps_pkg::REG_GAIN_I: begin
          regs.gain_i <= cfg.data[lsps_pkg::GAIN_BITS-1:0];
        end
        lsps_pkg::REG_GAIN_D: begin
          regs.gain_d <= cfg.data[lsps_pkg::GAIN_BITS-1:0];
        end
        lsps_pkg::REG_NOMINAL_SPEED: begin
          regs.nominal_speed <= cfg.data[lsps_pkg::SPEED_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lsps_front.sv
// Input register, threshold compare, pattern decode and tracking state (mode, integral,
// last error). Depends on lsps_pkg and lsps_sample_if.
`default_nettype none

module lsps_front (
  input  wire logic        clk,
  input  wire logic        rst,
  lsps_sample_if.sink      sample,
  input  lsps_pkg::cfg_t   regs,
  output logic             trk_valid,
  input  wire logic        trk_ready,
  output lsps_pkg::track_t trk
);

  logic                                        a_valid;
  lsps_pkg::samples_t                          a_samples;
  logic                                        a_en;
  logic                                        b_en;

  lsps_pkg::mode_t                             mode_reg;
  logic signed [lsps_pkg::ERR_BITS-1:0]        last_error;
  logic signed [lsps_pkg::INTEGRAL_BITS-1:0]   error_integral;

  logic [lsps_pkg::NUM_SENSORS-1:0]            bits;
  lsps_pkg::decode_t                           dec;
  lsps_pkg::mode_t                             mode_next;
  logic signed [lsps_pkg::INTEGRAL_BITS:0]     isum;
  logic signed [lsps_pkg::INTEGRAL_BITS-1:0]   error_integral_next;
  logic signed [lsps_pkg::DERIV_BITS-1:0]      deriv;

  assign b_en         = !trk_valid || trk_ready;
  assign a_en         = !a_valid || b_en;
  assign sample.ready = a_en;

  function automatic logic line_bit(
    input logic [lsps_pkg::SAMPLE_BITS-1:0]    s,
    input logic [lsps_pkg::THRESHOLD_BITS-1:0] thr,
    input logic                                dark
  );
    logic above;
    above = lsps_pkg::CMP_BITS'(s) >= lsps_pkg::CMP_BITS'(thr);
    return ~(above ^ dark);
  endfunction

  always_comb begin
    bits[4] = line_bit(a_samples.far_left,  regs.threshold, regs.line_is_dark);
    bits[3] = line_bit(a_samples.left,      regs.threshold, regs.line_is_dark);
    bits[2] = line_bit(a_samples.center,    regs.threshold, regs.line_is_dark);
    bits[1] = line_bit(a_samples.right,     regs.threshold, regs.line_is_dark);
    bits[0] = line_bit(a_samples.far_right, regs.threshold, regs.line_is_dark);
    dec       = lsps_pkg::decode_pattern(bits);
    mode_next = dec.hit ? dec.mode : mode_reg;
    isum = (lsps_pkg::INTEGRAL_BITS + 1)'(error_integral)
         + (lsps_pkg::INTEGRAL_BITS + 1)'(dec.err);
    if (isum > (lsps_pkg::INTEGRAL_BITS + 1)'(lsps_pkg::INT_MAX)) begin
      error_integral_next = lsps_pkg::INTEGRAL_BITS'(lsps_pkg::INT_MAX);
    end else if (isum < (lsps_pkg::INTEGRAL_BITS + 1)'(lsps_pkg::INT_MIN)) begin
      error_integral_next = lsps_pkg::INTEGRAL_BITS'(lsps_pkg::INT_MIN);
    end else begin
      error_integral_next = isum[lsps_pkg::INTEGRAL_BITS-1:0];
    end
    deriv = lsps_pkg::DERIV_BITS'(dec.err) - lsps_pkg::DERIV_BITS'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= sample.valid;
    end
    if (a_en && sample.valid) begin
      a_samples.far_left  <= sample.sample_far_left;
      a_samples.left      <= sample.sample_left;
      a_samples.center    <= sample.sample_center;
      a_samples.right     <= sample.sample_right;
      a_samples.far_right <= sample.sample_far_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_valid      <= 1'b0;
      mode_reg       <= lsps_pkg::MODE_STOPPED;
      last_error     <= '0;
      error_integral <= '0;
    end else if (b_en) begin
      trk_valid <= a_valid;
      if (a_valid) begin
        mode_reg       <= mode_next;
        last_error     <= dec.err;
        error_integral <= error_integral_next;
      end
    end
    if (b_en && a_valid) begin
      trk.err   <= dec.err;
      trk.mode  <= mode_next;
      trk.integ <= error_integral_next;
      trk.deriv <= deriv;
    end
  end

endmodule

`default_nettype wire

### rtl/lsps_pid.sv
// PID arithmetic: one stage of three gain products, one stage of sum, scale and saturate.
// Depends on lsps_pkg.
`default_nettype none

module lsps_pid (
  input  wire logic          clk,
  input  wire logic          rst,
  input  lsps_pkg::cfg_t     regs,
  input  wire logic          trk_valid,
  output logic               trk_ready,
  input  lsps_pkg::track_t   trk,
  output logic               pid_valid,
  input  wire logic          pid_ready,
  output lsps_pkg::pid_res_t pid_res
);

  localparam int SB = lsps_pkg::SUM_BITS;
  localparam int QB = lsps_pkg::QUOT_BITS;

  logic                                        c_valid;
  logic                                        c_en;
  logic                                        d_en;
  logic signed [lsps_pkg::ERR_BITS-1:0]        c_err;
  lsps_pkg::mode_t                             c_mode;
  logic signed [lsps_pkg::PROD_P_BITS-1:0]     prod_p;
  logic signed [lsps_pkg::PROD_I_BITS-1:0]     prod_i;
  logic signed [lsps_pkg::PROD_D_BITS-1:0]     prod_d;

  logic signed [lsps_pkg::GAIN_BITS:0]         gp;
  logic signed [lsps_pkg::GAIN_BITS:0]         gi;
  logic signed [lsps_pkg::GAIN_BITS:0]         gd;
  logic signed [lsps_pkg::PROD_P_BITS-1:0]     prod_p_next;
  logic signed [lsps_pkg::PROD_I_BITS-1:0]     prod_i_next;
  logic signed [lsps_pkg::PROD_D_BITS-1:0]     prod_d_next;

  logic signed [SB-1:0]                        sum;
  logic signed [SB-1:0]                        adj;
  logic signed [QB-1:0]                        quot;
  logic signed [lsps_pkg::OUT_BITS-1:0]        pid_next;

  assign d_en      = !pid_valid || pid_ready;
  assign c_en      = !c_valid || d_en;
  assign trk_ready = c_en;

  always_comb begin
    gp = $signed({1'b0, regs.gain_p});
    gi = $signed({1'b0, regs.gain_i});
    gd = $signed({1'b0, regs.gain_d});
    prod_p_next = gp * trk.err;
    prod_i_next = gi * trk.integ;
    prod_d_next = gd * trk.deriv;
  end

  // Division by 256 truncates toward zero: negative sums are biased before the shift.
  always_comb begin
    sum = SB'(prod_p) + SB'(prod_i) + SB'(prod_d);
    adj = sum + (sum[SB-1] ? SB'((1 << lsps_pkg::FRAC_BITS) - 1) : SB'(0));
    quot = adj[SB-1:lsps_pkg::FRAC_BITS];
    if (quot > QB'(lsps_pkg::OUT_MAX)) begin
      pid_next = lsps_pkg::OUT_BITS'(lsps_pkg::OUT_MAX);
    end else if (quot < QB'(lsps_pkg::OUT_MIN)) begin
      pid_next = lsps_pkg::OUT_BITS'(lsps_pkg::OUT_MIN);
    end else begin
      pid_next = quot[lsps_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= trk_valid;
    end
    if (c_en && trk_valid) begin
      c_err  <= trk.err;
      c_mode <= trk.mode;
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_valid <= 1'b0;
    end else if (d_en) begin
      pid_valid <= c_valid;
    end
    if (d_en && c_valid) begin
      pid_res.err  <= c_err;
      pid_res.mode <= c_mode;
      pid_res.pid  <= pid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lsps_out.sv
// Motor speed stage and output register of the result channel.
// Depends on lsps_pkg and lsps_result_if.
`default_nettype none

module lsps_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  lsps_pkg::cfg_t     regs,
  input  wire logic          pid_valid,
  output logic               pid_ready,
  input  lsps_pkg::pid_res_t pid_res,
  lsps_result_if.source      result
);

  localparam int W = lsps_pkg::SPD_SUM_BITS;

  logic                                 e_en;
  logic signed [W-1:0]                  nom;
  logic signed [W-1:0]                  pid_ext;
  logic signed [lsps_pkg::OUT_BITS-1:0] speed_a_next;
  logic signed [lsps_pkg::OUT_BITS-1:0] speed_b_next;

  assign e_en      = !result.valid || result.ready;
  assign pid_ready = e_en;

  always_comb begin
    nom          = $signed(W'(regs.nominal_speed));
    pid_ext      = W'(pid_res.pid);
    speed_a_next = lsps_pkg::sat_out(nom + pid_ext);
    speed_b_next = lsps_pkg::sat_out(nom - pid_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (e_en) begin
      result.valid <= pid_valid;
    end
    if (e_en && pid_valid) begin
      result.position_error <= pid_res.err;
      result.run_mode       <= pid_res.mode;
      result.pid_value      <= pid_res.pid;
      result.speed_a        <= speed_a_next;
      result.speed_b        <= speed_b_next;
    end
  end

endmodule

`default_nettype wire

### rtl/line_sensor_pid_steering_unit.sv
// Top level of the line-sensor PID steering unit: config registers, front end, PID, output.
// Depends on lsps_pkg, the three channel interfaces, lsps_cfg, lsps_front, lsps_pid, lsps_out.
//
//   Channel   Direction  Carries
//   sample    in         five sensor samples of one control tick
//   result    out        position error, run mode, PID value, two motor speeds
//   cfg       in         register index and write data, always ready
//
// One transfer is accepted per cycle while the result channel is not stalled; the result of a tick
// passes through the input register, decode/state, product, sum and output stages.
// Reset restores the register defaults and clears mode, last error and integral at once.
// Each stage has its own valid bit, so a stalled output only stops stages that are full.
`default_nettype none

module line_sensor_pid_steering_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  lsps_sample_if.sink   sample,
  lsps_result_if.source result,
  lsps_cfg_if.sink      cfg
);

  lsps_pkg::cfg_t     regs;
  logic               trk_valid;
  logic               trk_ready;
  lsps_pkg::track_t   trk;
  logic               pid_valid;
  logic               pid_ready;
  lsps_pkg::pid_res_t pid_res;

  lsps_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lsps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .regs      (regs),
    .trk_valid (trk_valid),
    .trk_ready (trk_ready),
    .trk       (trk)
  );

  lsps_pid u_pid (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .trk_valid (trk_valid),
    .trk_ready (trk_ready),
    .trk       (trk),
    .pid_valid (pid_valid),
    .pid_ready (pid_ready),
    .pid_res   (pid_res)
  );

  lsps_out u_out (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pid_valid (pid_valid),
    .pid_ready (pid_ready),
    .pid_res   (pid_res),
    .result    (result)
  );

endmodule

`default_nettype wire
